// ===== sv/ecm_pkg.sv =====
// shared types and constants of the event class hash map
// command and status bundles between controller and datapath, result select codes
// no dependencies
package ecm_pkg;

   localparam int KEY_W   = 16;
   localparam int CLASS_W = 32;

   // result select codes
   typedef logic [2:0] res_sel_type;
   localparam res_sel_type RES_NONE    = 3'd0; // absent on lookup
   localparam res_sel_type RES_FULL    = 3'd1; // new event dropped, pool exhausted
   localparam res_sel_type RES_NEW     = 3'd2; // new entry linked at chain head
   localparam res_sel_type RES_REPLACE = 3'd3; // class of existing entry overwritten
   localparam res_sel_type RES_READ    = 3'd4; // class read from the pool on lookup

   typedef struct packed {
      logic        capture;   // latch the accepted request
      logic        hash;      // register the quotient estimate key / BUCKETS
      logic        reduce;    // fold the quotient estimate into the bucket index
      logic        head_rd;   // read the bucket head
      logic        head_ld;   // load chain pointer from bucket head
      logic        ent_rd;    // read entry key and link at pointer
      logic        walk_next; // follow link to next entry
      logic        class_rd;  // read entry class at pointer
      logic        upd_class; // overwrite entry class at pointer
      logic        ins;       // link a new entry at the chain head
      logic        res_load;  // capture result
      res_sel_type res_sel;
      logic        out_load;  // move result into the output register
      logic        clr_step;  // clear one bucket head
   } cmd_type;

   typedef struct packed {
      logic clr_last;  // last bucket of the clearing pass
      logic ptr_zero;  // end of chain
      logic key_match; // entry key equals request key
      logic is_insert; // latched request is an insert
      logic pool_full; // every pool entry in use
   } sts_type;

endpackage

// ===== sv/ecm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ecm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ecm_dpath.sv =====
// datapath of the event class hash map: request and pointer registers, pool memories
// depends on ecm_pkg and ecm_ram
module ecm_dpath #(
   parameter int BUCKETS  = 251,
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [47:0]       req_tdata, // event_number, class_bits
   input  logic              req_tuser, // req_type
   input  ecm_pkg::cmd_type  cmd,
   output ecm_pkg::sts_type  sts,
   output logic [31:0]       rsp_tdata, // class_out
   output logic [1:0]        rsp_tuser  // found, table_full
);
   import ecm_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_W + PW;

   // reciprocal of the bucket count, scaled by 2^RS; the estimate is low by at most one
   localparam int          RS        = KEY_W + 10;
   localparam int          RW        = RS + 1;
   localparam logic [RS:0] RECIP     = RW'((64'd1 << RS) / BUCKETS);
   localparam logic [10:0] BUCKETS_C = 11'(BUCKETS);

   logic               insert_ff, insert_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;
   logic [KEY_W-1:0]   quot_ff, quot_in;
   logic [BW-1:0]      bucket_ff, bucket_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      free_ff, free_in;
   logic [BW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [CLASS_W-1:0] res_class_ff, res_class_in;
   logic               res_found_ff, res_found_in;
   logic               res_full_ff, res_full_in;
   logic [CLASS_W-1:0] out_class_ff, out_class_in;
   logic               out_found_ff, out_found_in;
   logic               out_full_ff, out_full_in;

   logic [KEY_W+RW-1:0] recip_prod;
   logic [KEY_W+10:0]   quot_mul;
   logic [KEY_W-1:0]    rem_raw;
   logic [KEY_W-1:0]    rem_fix;
   logic [PW-1:0]      ptr_m1;
   logic [IW-1:0]      idx_cur;
   logic [IW-1:0]      idx_free;
   logic [PW-1:0]      head_rdata;
   logic [EW-1:0]      ent_rdata;
   logic [CLASS_W-1:0] class_rdata;
   logic               bkt_we;
   logic [BW-1:0]      bkt_waddr;
   logic [PW-1:0]      bkt_wdata;
   logic               cls_we;
   logic [IW-1:0]      cls_waddr;

   assign ptr_m1   = ptr_ff - PW'(1);
   assign idx_cur  = ptr_m1[IW-1:0];
   assign idx_free = free_ff[IW-1:0];

   // bucket index in two steps: quotient estimate, then remainder with one correction
   assign recip_prod = {{RW{1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
   assign quot_mul   = {11'b0, quot_ff} * {{KEY_W{1'b0}}, BUCKETS_C};
   assign rem_raw    = key_ff - quot_mul[KEY_W-1:0];
   assign rem_fix    = (rem_raw >= KEY_W'(BUCKETS)) ? rem_raw - KEY_W'(BUCKETS) : rem_raw;

   // bucket heads: cleared by the sweep, rewritten on insert
   assign bkt_we    = cmd.clr_step | cmd.ins;
   assign bkt_waddr = cmd.clr_step ? clr_cnt_ff : bucket_ff;
   assign bkt_wdata = cmd.clr_step ? '0 : free_ff + PW'(1);

   assign cls_we    = cmd.upd_class | cmd.ins;
   assign cls_waddr = cmd.ins ? idx_free : idx_cur;

   ecm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_en   (cmd.head_rd),
      .rd_addr (bucket_ff),
      .rd_data (head_rdata)
   );

   // entry key in the upper bits, link in the lower
   ecm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.ins),
      .wr_addr (idx_free),
      .wr_data ({key_ff, head_ff}),
      .rd_en   (cmd.ent_rd),
      .rd_addr (idx_cur),
      .rd_data (ent_rdata)
   );

   ecm_ram #(.WIDTH(CLASS_W), .DEPTH(CAPACITY)) u_class_ram (
      .clock   (clock),
      .wr_en   (cls_we),
      .wr_addr (cls_waddr),
      .wr_data (cls_ff),
      .rd_en   (cmd.class_rd),
      .rd_addr (idx_cur),
      .rd_data (class_rdata)
   );

   always_comb begin
      insert_in    = insert_ff;
      key_in       = key_ff;
      cls_in       = cls_ff;
      quot_in      = quot_ff;
      bucket_in    = bucket_ff;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      clr_cnt_in   = clr_cnt_ff;
      res_class_in = res_class_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      out_class_in = out_class_ff;
      out_found_in = out_found_ff;
      out_full_in  = out_full_ff;

      if (cmd.capture) begin
         insert_in = req_tuser;
         key_in    = req_tdata[KEY_W-1:0];
         cls_in    = req_tdata[KEY_W+CLASS_W-1:KEY_W];
      end
      if (cmd.hash) begin
         quot_in = recip_prod[RS+KEY_W-1:RS];
      end
      if (cmd.reduce) begin
         bucket_in = rem_fix[BW-1:0];
      end
      if (cmd.head_ld) begin
         ptr_in  = head_rdata;
         head_in = head_rdata;
      end
      if (cmd.walk_next) begin
         ptr_in = ent_rdata[PW-1:0];
      end
      if (cmd.ins) begin
         free_in = free_ff + PW'(1);
      end
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + BW'(1);
      end
      if (cmd.res_load) begin
         unique case (cmd.res_sel)
            RES_NONE: begin
               res_class_in = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
            end
            RES_FULL: begin
               res_class_in = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b1;
            end
            RES_NEW: begin
               res_class_in = cls_ff;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
            end
            RES_REPLACE: begin
               res_class_in = cls_ff;
               res_found_in = 1'b1;
               res_full_in  = 1'b0;
            end
            RES_READ: begin
               res_class_in = class_rdata;
               res_found_in = 1'b1;
               res_full_in  = 1'b0;
            end
            default: begin
               res_class_in = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_class_in = res_class_ff;
         out_found_in = res_found_ff;
         out_full_in  = res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         free_ff    <= free_in;
         clr_cnt_ff <= clr_cnt_in;
      end
      insert_ff    <= insert_in;
      key_ff       <= key_in;
      cls_ff       <= cls_in;
      quot_ff      <= quot_in;
      bucket_ff    <= bucket_in;
      ptr_ff       <= ptr_in;
      head_ff      <= head_in;
      res_class_ff <= res_class_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      out_class_ff <= out_class_in;
      out_found_ff <= out_found_in;
      out_full_ff  <= out_full_in;
   end

   assign sts.clr_last  = (clr_cnt_ff == BW'(BUCKETS - 1));
   assign sts.ptr_zero  = (ptr_ff == '0);
   assign sts.key_match = (ent_rdata[EW-1:PW] == key_ff);
   assign sts.is_insert = insert_ff;
   assign sts.pool_full = (free_ff == PW'(CAPACITY));

   assign rsp_tdata = out_class_ff;
   assign rsp_tuser = {out_full_ff, out_found_ff};

endmodule

// ===== sv/ecm_ctrl.sv =====
// controller of the event class hash map: clearing sweep, chain walk sequencing, handshakes
// depends on ecm_pkg
module ecm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ecm_pkg::cmd_type  cmd,
   input  ecm_pkg::sts_type  sts
);
   import ecm_pkg::*;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_HASH    = 4'd2;
   localparam logic [3:0] S_HEAD_RD = 4'd3;
   localparam logic [3:0] S_HEAD_LD = 4'd4;
   localparam logic [3:0] S_WALK    = 4'd5;
   localparam logic [3:0] S_CMP     = 4'd6;
   localparam logic [3:0] S_CLS_LD  = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;
   localparam logic [3:0] S_REDUCE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_HEAD_LD;
         end
         S_HEAD_LD: begin
            cmd.head_ld = 1'b1;
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (!sts.ptr_zero) begin
               cmd.ent_rd = 1'b1;
               state_in   = S_CMP;
            end else begin
               cmd.res_load = 1'b1;
               state_in     = S_RESP;
               if (!sts.is_insert) begin
                  cmd.res_sel = RES_NONE;
               end else if (sts.pool_full) begin
                  cmd.res_sel = RES_FULL;
               end else begin
                  cmd.ins     = 1'b1;
                  cmd.res_sel = RES_NEW;
               end
            end
         end
         S_CMP: begin
            if (!sts.key_match) begin
               cmd.walk_next = 1'b1;
               state_in      = S_WALK;
            end else if (sts.is_insert) begin
               cmd.upd_class = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_sel   = RES_REPLACE;
               state_in      = S_RESP;
            end else begin
               cmd.class_rd = 1'b1;
               state_in     = S_CLS_LD;
            end
         end
         S_CLS_LD: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_READ;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken transaction");

   a_accept_to_hash: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_HASH))
      else $error("accepted transaction not sequenced");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |-> !sts.pool_full)
      else $error("insert with exhausted pool");

   a_no_read_null: assert property (@(posedge clock) disable iff (reset)
      cmd.ent_rd |-> !sts.ptr_zero)
      else $error("entry read at end of chain");

   a_no_ready_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!req_tready && !rsp_valid_ff))
      else $error("handshake active during clearing sweep");

endmodule

// ===== sv/event_class_hash_map.sv =====
// event class hash map: 16-bit event number to 32-bit class mask, chained hash table
// sequence: after acceptance hash, reduce, head read, head load, then per visited chain entry
//   a key/link read and a compare; a lookup hit adds a class read; the hand-off waits on rsp_tready
// throughput: one transaction at a time, req_tready returns the cycle after the result is loaded
// reset: synchronous; a sweep then empties every bucket head, req_tready low
// depends on ecm_pkg, ecm_ctrl, ecm_dpath, ecm_ram
module event_class_hash_map #(
   parameter int BUCKETS  = 251,  // hash bucket count, bucket = event_number mod BUCKETS
   parameter int CAPACITY = 1024  // pool entries
) (
   input  logic        clock,
   input  logic        reset,
   // request transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [15:0] event_number, [47:16] class_bits
   input  logic        req_tuser,  // [0] req_type: 0 lookup, 1 insert or replace
   // result transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] class_out
   output logic [1:0]  rsp_tuser   // [0] found, [1] table_full
);
   import ecm_pkg::*;

   // command and status bundles between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing sweep, bucket index by hash then reduce, bucket head read, chain walk,
   // result hand-off; each visited entry takes a key/link read and then a compare
   ecm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: request latch, reciprocal hash, chain pointer, pool memories, output register
   // pool entries are not cleared on reset and the fill count restarts at zero
   ecm_dpath #(
      .BUCKETS  (BUCKETS),
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== verif/tb_event_class_hash_map.sv =====
`timescale 1ns / 100ps
// testbench for event_class_hash_map: lookups and inserts on the chained event class table,
// checked against a table model held in a small scoreboard class
// depends on ecm_pkg and the event_class_hash_map rtl
module tb_event_class_hash_map;

   localparam int BUCKETS   = 251;
   localparam int CAPACITY  = 1024;
   localparam int LIMIT     = 5000000;  // timeout in clock cycles
   localparam int MAX_NOTES = 30;       // mismatch reports before going quiet

   typedef bit [ecm_pkg::KEY_W-1:0]   key_type;
   typedef bit [ecm_pkg::CLASS_W-1:0] mask_type;

   typedef enum bit {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   // what the block should answer for one request
   typedef struct packed {
      mask_type class_mask;
      bit       found;
      bit       full;
   } answer_type;

   // table model plus the queue of answers still owed by the block
   class event_map_model;
      bit [10:0]   head_of [BUCKETS];   // 0 = empty chain, else entry + 1
      key_type     key_at  [CAPACITY];
      mask_type    mask_at [CAPACITY];
      bit [10:0]   next_at [CAPACITY];  // 0 = end of chain, else entry + 1
      int unsigned used;
      answer_type  owed [$];
      int unsigned errors, checked;
      int unsigned n_lookup, n_hit, n_new, n_replace, n_drop;

      function new();
         used = 0;
         errors = 0;
         checked = 0;
         n_lookup = 0;
         n_hit = 0;
         n_new = 0;
         n_replace = 0;
         n_drop = 0;
         foreach (head_of[b]) head_of[b] = '0;
      endfunction

      // update the table for one accepted request and queue its answer
      function void note_request(op_type op, key_type key, mask_type mask);
         int         bucket;
         int         ptr;
         int         hit;
         int         steps;
         answer_type ans;
         bucket = int'(key) % BUCKETS;
         ptr    = head_of[bucket];
         hit    = 0;
         steps  = 0;
         // walk the chain, bounded by the pool size
         while (ptr != 0 && hit == 0 && steps < CAPACITY) begin
            if (key_at[ptr-1] == key) hit = ptr;
            else ptr = next_at[ptr-1];
            steps++;
         end
         ans = '0;
         if (op == OP_LOOKUP) begin
            n_lookup++;
            if (hit != 0) begin
               ans.class_mask = mask_at[hit-1];
               ans.found      = 1'b1;
               n_hit++;
            end
         end else if (hit != 0) begin
            mask_at[hit-1] = mask;
            ans.class_mask = mask;
            ans.found      = 1'b1;
            n_replace++;
         end else if (used >= CAPACITY) begin
            ans.full = 1'b1;
            n_drop++;
         end else begin
            key_at[used]    = key;
            mask_at[used]   = mask;
            next_at[used]   = head_of[bucket];
            head_of[bucket] = 11'(used + 1);
            used++;
            ans.class_mask  = mask;
            n_new++;
         end
         owed.push_back(ans);
      endfunction

      function void note_error(string what, longint unsigned exp_v, longint unsigned act_v);
         errors++;
         if (errors <= MAX_NOTES)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      endfunction

      // compare one accepted result against the oldest owed answer
      function void check_response(mask_type mask, bit found, bit full);
         answer_type ans;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= MAX_NOTES)
               $display("%0t: unexpected result, expected none, actual class %h found %b full %b",
                        $time, mask, found, full);
            return;
         end
         ans = owed.pop_front();
         checked++;
         if (mask != ans.class_mask) note_error("class_out", ans.class_mask, mask);
         if (found != ans.found) note_error("found", ans.found, found);
         if (full != ans.full) note_error("table_full", ans.full, full);
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [15:0] event_number, [47:16] class_bits
   logic        req_tuser;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] class_out
   logic [1:0]  rsp_tuser;   // [0] found, [1] table_full

   event_map_model model;
   key_type        used_keys [$];   // every key ever sent in an insert
   int unsigned    cycle_count;
   int             burst_left;
   bit             no_idle;         // a stretch where the sender never pauses

   event_class_hash_map #(
      .BUCKETS  (BUCKETS),
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // hard stop if the block hangs
   initial begin
      while (cycle_count < LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d results outstanding", $time, model.pending());
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check each accepted transaction, then pick the next ready value.
   // the stall mode is redrawn at random from: always ready, mostly ready, slow, bursty
   int unsigned rx_cycles = 0;
   int unsigned stall_mode = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.check_response(rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles % 256 == 255) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 4) == 0);
         end
         default: begin
            // alternating equal stretches of ready and stalled
            rsp_tready <= ((rx_cycles / 8) % 2 == 0);
         end
      endcase
   end

   // hold one request until the block takes it, then record it.
   // valid stays high so a following request can go out on the next edge
   task automatic send_request(op_type op, key_type key, mask_type mask);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {mask, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model.note_request(op, key, mask);
      if (op == OP_INSERT) used_keys.push_back(key);
   endtask

   // sender idling: bursts of random length with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 9);
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, 16'($urandom)};
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int      issued;
      int      after_full;
      int      pick;
      int      reuse;
      op_type  op;
      key_type key;

      model       = new();
      cycle_count = 0;
      burst_left  = 0;
      no_idle     = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part: empty table, field extremes, a shared bucket, replace
      send_request(OP_LOOKUP, 16'd0, 32'h0);            // lookup on an empty table
      pace_sender();
      send_request(OP_INSERT, 16'd0, 32'h0000_0000);    // smallest key and class
      pace_sender();
      send_request(OP_INSERT, 16'hffff, 32'hffff_ffff); // largest key and class
      pace_sender();
      send_request(OP_LOOKUP, 16'd0, 32'hffff_ffff);    // class_bits ignored on lookup
      pace_sender();
      send_request(OP_LOOKUP, 16'hffff, 32'h0);
      pace_sender();
      // 0, 251 and 502 share bucket 0, so they build one chain
      send_request(OP_INSERT, 16'd251, 32'h5a5a_5a5a);
      pace_sender();
      send_request(OP_INSERT, 16'd502, 32'ha5a5_a5a5);
      pace_sender();
      send_request(OP_LOOKUP, 16'd251, 32'h0);          // middle of the chain
      pace_sender();
      send_request(OP_LOOKUP, 16'd0, 32'h0);            // tail of the chain
      pace_sender();
      send_request(OP_LOOKUP, 16'd502, 32'h0);          // head of the chain
      pace_sender();
      send_request(OP_LOOKUP, 16'd753, 32'h0);          // absent from a non-empty bucket
      pace_sender();
      send_request(OP_INSERT, 16'd251, 32'h0000_0000);  // replace with zero
      pace_sender();
      send_request(OP_INSERT, 16'hffff, 32'h1234_5678); // replace the top key
      pace_sender();
      send_request(OP_LOOKUP, 16'd251, 32'h0);          // found with a zero class
      pace_sender();
      send_request(OP_LOOKUP, 16'hffff, 32'h0);
      pace_sender();
      send_request(OP_INSERT, 16'd250, 32'h8000_0001);  // last bucket
      pace_sender();
      send_request(OP_LOOKUP, 16'd250, 32'h0);
      pace_sender();
      send_request(OP_INSERT, 16'd65511, 32'h0000_0001); // 261 * 251, bucket 0 again
      pace_sender();
      send_request(OP_LOOKUP, 16'd65511, 32'h0);
      pace_sender();

      // random part: fill the pool through to exhaustion, then keep going a while
      // so that dropped inserts mix with lookups and replaces on a full table
      issued     = 0;
      after_full = 0;
      while (!(model.used >= CAPACITY && after_full >= 100) && issued < 3000) begin
         no_idle = (issued % 400) >= 300;
         pick = $urandom_range(0, 99);
         if (model.used < CAPACITY) op = (pick < 96) ? OP_INSERT : OP_LOOKUP;
         else op = (pick < 55) ? OP_INSERT : OP_LOOKUP;
         // mostly fresh keys while filling, many known keys once the pool is full
         reuse = (model.used < CAPACITY) ? 4 : 40;
         pick = $urandom_range(0, 99);
         if (used_keys.size() > 0 && pick < reuse)
            key = used_keys[$urandom_range(0, used_keys.size() - 1)];
         else if (pick < reuse + 16)
            // crowd a few buckets so some chains grow long
            key = 16'($urandom_range(0, 3) + 251 * $urandom_range(0, 260));
         else
            key = 16'($urandom);
         send_request(op, key, $urandom);
         issued++;
         if (model.used >= CAPACITY) after_full++;
         pace_sender();
      end
      req_tvalid <= 1'b0;

      // drain, then give the block room to show any stray result
      while (model.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d lookups (%0d hits) and %0d inserts: %0d new, %0d replaced,",
               model.n_lookup, model.n_hit, model.n_new + model.n_replace + model.n_drop,
               model.n_new, model.n_replace);
      $display("%0d dropped on a full pool of %0d entries; %0d results checked, %0d errors",
               model.n_drop, model.used, model.checked, model.errors);
      if (model.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
